FILE: hdl/bucketed_hash_index_probing_top_macros.svh
// Assertion helpers shared by the hash index RTL.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef BUCKETED_HASH_INDEX_PROBING_TOP_MACROS_SVH
`define BUCKETED_HASH_INDEX_PROBING_TOP_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold.
`define BHIP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash index assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define BHIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash index assertion failed");

`endif

FILE: hdl/bhip_pkg.sv
package bhip_pkg;

  // Table geometry.
  localparam int BUCKETS = 1024;
  localparam int SLOTS = 2;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths.
  localparam int KIND_W = 2;
  localparam int KEY_W = 31;
  localparam int OFFSET_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;
  localparam int LIMIT_W = 11;
  localparam int TAG_W = 2;
  localparam int ENTRY_W = KEY_W + OFFSET_W;
  localparam int TAG_ROW_W = SLOTS * TAG_W;
  localparam int DATA_ROW_W = SLOTS * ENTRY_W;

  // Multiplicative hash: the fraction is the low FRAC_W bits of key * HASH_MUL.
  localparam int FRAC_W = 24;
  localparam logic [FRAC_W-1:0] HASH_MUL = 24'd10368890;

  // Largest usable probe limit.
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 11'd1024;

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Operation codes on the kind port.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Slot tags.
  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_LIVE = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TOMB = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_LIMIT = 1'b1;

  // Decoded operation.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // One classified request waiting for the probe engine.
  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [OFFSET_W-1:0] offset;
    logic [BUCKET_W-1:0] home;
  } req_t;

  // One finished result.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] found_offset;
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } result_t;

  // Effective configuration seen by the probe engine.
  typedef struct packed {
    logic               quadratic;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  // Write side of the bucket memories.
  typedef struct packed {
    logic                  tag_we;
    logic                  data_we;
    logic [BUCKET_W-1:0]   waddr;
    logic [TAG_ROW_W-1:0]  tag_wdata;
    logic [DATA_ROW_W-1:0] data_wdata;
  } ram_wr_t;

endpackage

FILE: hdl/bhip_ram.sv
module bhip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bhip_front.sv
module bhip_front
  import bhip_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KIND_W-1:0]   kind,
  input  logic [KEY_W-1:0]    key,
  input  logic [OFFSET_W-1:0] record_offset,
  input  logic                clearing,
  input  logic                q_full,
  output logic                busy,
  output logic                push,
  output req_t                push_req
);

  logic             stage_valid;
  req_t             stage_req;
  logic             accept;
  op_t              op_dec;
  logic [FRAC_W-1:0] frac;

  // Only the low fraction bits of the product are needed, so the key is cut to match.
  assign frac = key[FRAC_W-1:0] * HASH_MUL;

  // Kind three is treated as a search.
  always_comb begin
    unique case (kind)
      KIND_INSERT: op_dec = OP_INSERT;
      KIND_DELETE: op_dec = OP_DELETE;
      default:     op_dec = OP_SEARCH;
    endcase
  end

  // The stage frees up when its request moves into the queue.
  assign push = stage_valid && !q_full;
  assign busy = clearing || (stage_valid && q_full);
  assign accept = start && !busy;
  assign push_req = stage_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  // Classified request with its home bucket taken from the top fraction bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_req.op <= op_dec;
      stage_req.key <= key;
      stage_req.offset <= record_offset;
      stage_req.home <= frac[FRAC_W-1 -: BUCKET_W];
    end
  end

endmodule

FILE: hdl/bhip_queue.sv
module bhip_queue
  import bhip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t head,
  output logic empty,
  output logic full
);

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign empty = (fill == '0);
  assign full = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

FILE: hdl/bhip_back.sv
module bhip_back
  import bhip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  req_t                  head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  clearing,
  output logic [BUCKET_W-1:0]   raddr,
  input  logic [TAG_ROW_W-1:0]  tag_row,
  input  logic [DATA_ROW_W-1:0] data_row,
  output ram_wr_t               ram_wr,
  output logic                  done,
  output result_t               result
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  state_t              state;
  logic [BUCKET_W-1:0] clear_cnt;
  req_t                cur;
  logic [BUCKET_W-1:0] cur_bucket;
  logic [COUNT_W-1:0]  step;

  logic [SLOTS-1:0]    is_empty;
  logic [SLOTS-1:0]    is_hit;
  logic [SLOT_W-1:0]   empty_slot;
  logic [SLOT_W-1:0]   hit_slot;
  logic [SLOT_W-1:0]   sel_slot;
  logic [OFFSET_W-1:0] hit_offset;
  logic                finish_ok;
  logic                finish_miss;
  logic                at_limit;
  logic                finish;
  logic [BUCKET_W-1:0] incr;
  logic [BUCKET_W-1:0] bucket_next;
  logic [TAG_W-1:0]    new_tag;

  assign clearing = (state == S_CLEAR);
  assign pop = (state == S_IDLE) && !q_empty;

  // Classify the slots of the bucket just read; the lowest slot wins.
  always_comb begin
    is_empty = '0;
    is_hit = '0;
    empty_slot = '0;
    hit_slot = '0;
    hit_offset = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      is_empty[s] = (tag_row[s*TAG_W +: TAG_W] == TAG_EMPTY);
      is_hit[s] = (tag_row[s*TAG_W +: TAG_W] == TAG_LIVE) &&
                  (data_row[s*ENTRY_W +: KEY_W] == cur.key);
      if (is_empty[s]) begin
        empty_slot = SLOT_W'(s);
      end
      if (is_hit[s]) begin
        hit_slot = SLOT_W'(s);
        hit_offset = data_row[s*ENTRY_W + KEY_W +: OFFSET_W];
      end
    end
  end

  // Decide how this bucket ends the walk. A match beats an empty slot in the same bucket.
  assign finish_ok = (cur.op == OP_INSERT) ? (|is_empty) : (|is_hit);
  assign finish_miss = (cur.op != OP_INSERT) && !(|is_hit) && (|is_empty);
  assign at_limit = (step == cfg.limit);
  assign finish = finish_ok || finish_miss || at_limit;
  assign sel_slot = (cur.op == OP_INSERT) ? empty_slot : hit_slot;
  assign new_tag = (cur.op == OP_INSERT) ? TAG_LIVE : TAG_TOMB;

  // Next probe bucket: step c to c+1 adds 1 (linear) or 2c+1 (quadratic), wrapping.
  assign incr = cfg.quadratic ? {step[BUCKET_W-2:0], 1'b1} : BUCKET_W'(1);
  assign bucket_next = cur_bucket + incr;

  // Both memories are read at the home bucket on a pop and at the next bucket otherwise.
  assign raddr = (state == S_IDLE) ? head.home : bucket_next;

  // Row write-back: the clearing pass zeroes tags; a delete hit or an insert rewrites one slot.
  always_comb begin
    ram_wr.tag_wdata = tag_row;
    ram_wr.data_wdata = data_row;
    for (int s = 0; s < SLOTS; s++) begin
      if (sel_slot == SLOT_W'(s)) begin
        ram_wr.tag_wdata[s*TAG_W +: TAG_W] = new_tag;
        ram_wr.data_wdata[s*ENTRY_W +: ENTRY_W] = {cur.offset, cur.key};
      end
    end
    if (clearing) begin
      ram_wr.tag_wdata = '0;
    end
    ram_wr.waddr = clearing ? clear_cnt : cur_bucket;
    ram_wr.tag_we = clearing ||
                    ((state == S_EVAL) && finish_ok && (cur.op != OP_SEARCH));
    ram_wr.data_we = (state == S_EVAL) && finish_ok && (cur.op == OP_INSERT);
  end

  // Control: clearing pass, then one bucket per cycle for each request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clear_cnt <= clear_cnt + BUCKET_W'(1);
          if (clear_cnt == BUCKET_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (finish) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request and walk registers, and the result register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cur_bucket <= head.home;
      step <= '0;
    end else if ((state == S_EVAL) && !finish) begin
      cur_bucket <= bucket_next;
      step <= step + COUNT_W'(1);
    end
    if ((state == S_EVAL) && finish) begin
      if (finish_ok) begin
        result.status <= ST_DONE;
      end else if (cur.op == OP_INSERT) begin
        result.status <= ST_FULL;
      end else begin
        result.status <= ST_NOT_FOUND;
      end
      result.found_offset <= (finish_ok && (cur.op != OP_INSERT)) ? hit_offset : '0;
      result.bucket <= finish_ok ? cur_bucket : '0;
      result.slot <= finish_ok ? sel_slot : '0;
      result.count <= step + COUNT_W'(1);
    end
  end

endmodule

FILE: hdl/bucketed_hash_index_probing_top.sv
// Hash index of 1024 buckets with two slots each, keyed by a multiplicative hash,
// with linear or quadratic probing. After reset the block clears its tag memory
// and holds busy high; configuration writes are taken meanwhile.
// A request is taken when start is high and busy is low and passes through a
// registered hashing stage into a two-entry queue, so up to three requests can be
// waiting. The probe engine first fetches the home bucket, then examines one
// bucket per cycle, and takes the next request only after the current one has
// finished. Each request yields one result, shown for a single cycle with done
// high. The receiver cannot stall: whatever is on the result ports while done is
// high must be taken in that cycle.
module bucketed_hash_index_probing_top
  import bhip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      kind,
  input  logic [KEY_W-1:0]       key,
  input  logic [OFFSET_W-1:0]    record_offset,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data,
  output logic                   done,
  output logic [STATUS_W-1:0]    status,
  output logic [OFFSET_W-1:0]    found_offset,
  output logic [BUCKET_W-1:0]    bucket_index,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [COUNT_W-1:0]     probe_count
);

`include "bucketed_hash_index_probing_top_macros.svh"

  logic                  probe_mode;
  logic [LIMIT_W-1:0]    probe_limit;
  cfg_t                  cfg;
  logic                  clearing;
  logic                  q_full;
  logic                  q_empty;
  logic                  push;
  logic                  pop;
  req_t                  push_req;
  req_t                  head;
  logic [BUCKET_W-1:0]   raddr;
  logic [TAG_ROW_W-1:0]  tag_row;
  logic [DATA_ROW_W-1:0] data_row;
  ram_wr_t               ram_wr;
  result_t               result;
  logic [COUNT_W-1:0]    count_max;
  logic                  miss_clean;

  // Configuration registers; writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode <= 1'b0;
      probe_limit <= LIMIT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PROBE_MODE) begin
        probe_mode <= cfg_data[0];
      end else begin
        probe_limit <= cfg_data;
      end
    end
  end

  // A limit of zero acts as one, and anything above the maximum acts as the maximum.
  always_comb begin
    cfg.quadratic = probe_mode;
    priority if (probe_limit == '0) begin
      cfg.limit = LIMIT_W'(1);
    end else if (probe_limit > LIMIT_MAX) begin
      cfg.limit = LIMIT_MAX;
    end else begin
      cfg.limit = probe_limit;
    end
  end

  bhip_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .key           (key),
    .record_offset (record_offset),
    .clearing      (clearing),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_req      (push_req)
  );

  bhip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  bhip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .raddr    (raddr),
    .tag_row  (tag_row),
    .data_row (data_row),
    .ram_wr   (ram_wr),
    .done     (done),
    .result   (result)
  );

  // Slot tags, one row per bucket; cleared by the pass after reset.
  bhip_ram #(
    .WIDTH (TAG_ROW_W),
    .DEPTH (BUCKETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_wr.tag_we),
    .waddr (ram_wr.waddr),
    .wdata (ram_wr.tag_wdata),
    .raddr (raddr),
    .rdata (tag_row)
  );

  // Keys and record offsets, one row per bucket.
  bhip_ram #(
    .WIDTH (DATA_ROW_W),
    .DEPTH (BUCKETS)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_wr.data_we),
    .waddr (ram_wr.waddr),
    .wdata (ram_wr.data_wdata),
    .raddr (raddr),
    .rdata (data_row)
  );

  assign status = result.status;
  assign found_offset = result.found_offset;
  assign bucket_index = result.bucket;
  assign slot_index = result.slot;
  assign probe_count = result.count;

  // Bounds used by the checks below.
  assign count_max = cfg.limit + COUNT_W'(1);
  assign miss_clean = (found_offset == '0) && (bucket_index == '0) && (slot_index == '0);

  // No request may enter while the tag memory is being cleared.
  `BHIP_ASSERT_IMPL(a_busy_while_clearing, clearing, busy)
  // The walk never examines more buckets than the limit allows.
  `BHIP_ASSERT_IMPL(a_count_in_range, done, (probe_count != '0) && (probe_count <= count_max))
  // A miss or a full table reports no location and no offset.
  `BHIP_ASSERT_IMPL(a_miss_is_clean, done && (status != ST_DONE), miss_clean)
  // Every request first fetches its home bucket, so results never come back to back.
  `BHIP_ASSERT_NEXT(a_done_spaced, done, !done)

endmodule

FILE: tb/bucketed_hash_index_probing_top_tb.sv
module bucketed_hash_index_probing_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhip_pkg::*;

  // The spare operation code, which the block treats as a search.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  // Adding a multiple of this to a key keeps its home bucket unchanged.
  localparam logic [KEY_W-1:0] FAMILY_STEP = 31'h0100_0000;
  localparam logic [KEY_W-1:0] FAMILY_2 = 31'h0200_0000;
  localparam logic [KEY_W-1:0] FAMILY_3 = 31'h0300_0000;
  localparam logic [KEY_W-1:0] FAMILY_4 = 31'h0400_0000;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 230;
  localparam int POOL_MAX = 48;

  // One directed row: an optional register write, then one request.
  typedef struct packed {
    logic                   cfg_en;
    logic [CFG_INDEX_W-1:0] cfg_idx;
    logic [LIMIT_W-1:0]     cfg_val;
    logic [KIND_W-1:0]      op;
    logic [KEY_W-1:0]       key;
    logic [OFFSET_W-1:0]    ofs;
    logic                   typed;
    result_t                res;
  } probe_case_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [KIND_W-1:0]      kind;
  logic [KEY_W-1:0]       key;
  logic [OFFSET_W-1:0]    record_offset;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]     cfg_data;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [OFFSET_W-1:0]    found_offset;
  logic [BUCKET_W-1:0]    bucket_index;
  logic [SLOT_W-1:0]      slot_index;
  logic [COUNT_W-1:0]     probe_count;

  // Shadow copy of the bucket store and of the two registers.
  logic [TAG_W-1:0]    tag_store    [BUCKETS*SLOTS];
  logic [KEY_W-1:0]    key_store    [BUCKETS*SLOTS];
  logic [OFFSET_W-1:0] offset_store [BUCKETS*SLOTS];
  logic                cfg_quadratic;
  logic [LIMIT_W-1:0]  cfg_limit;

  result_t           pending_replies [$];
  probe_case_t       directed_cases [$];
  logic [FRAC_W-1:0] cluster_base [6];
  int                mismatches = 0;

  bucketed_hash_index_probing_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .key           (key),
    .record_offset (record_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .found_offset  (found_offset),
    .bucket_index  (bucket_index),
    .slot_index    (slot_index),
    .probe_count   (probe_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walks the probe path of one request over the shadow store and returns its result.
  function automatic result_t walk_table(input logic [KIND_W-1:0] op,
                                         input logic [KEY_W-1:0] k,
                                         input logic [OFFSET_W-1:0] ofs);
    result_t     r;
    logic [63:0] prod;
    int unsigned home, lim, b, idx, step;
    bit          finished, has_empty;
    prod = 64'(k) * 64'(HASH_MUL);
    home = int'((64'(prod[FRAC_W-1:0]) * 64'(BUCKETS)) >> FRAC_W);
    if (cfg_limit == '0) lim = 1;
    else if (cfg_limit > LIMIT_MAX) lim = 32'(LIMIT_MAX);
    else lim = 32'(cfg_limit);
    r = '0;
    r.status = (op == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
    finished = 1'b0;
    step = 0;
    while (step <= lim && !finished) begin
      if (step == 0) b = home;
      else if (cfg_quadratic) b = (home + step * step) % BUCKETS;
      else b = (home + step) % BUCKETS;
      has_empty = 1'b0;
      r.count = COUNT_W'(step + 1);
      for (int s = 0; s < SLOTS && !finished; s++) begin
        idx = b * SLOTS + s;
        if (op == KIND_INSERT) begin
          // Insert takes the first empty slot; tombstones are skipped.
          if (tag_store[idx] == TAG_EMPTY) begin
            tag_store[idx] = TAG_LIVE;
            key_store[idx] = k;
            offset_store[idx] = ofs;
            r.status = ST_DONE;
            r.bucket = BUCKET_W'(b);
            r.slot = SLOT_W'(s);
            finished = 1'b1;
          end
        end else if (tag_store[idx] == TAG_EMPTY) begin
          has_empty = 1'b1;
        end else if (tag_store[idx] == TAG_LIVE && key_store[idx] == k) begin
          r.found_offset = offset_store[idx];
          if (op == KIND_DELETE) tag_store[idx] = TAG_TOMB;
          r.status = ST_DONE;
          r.bucket = BUCKET_W'(b);
          r.slot = SLOT_W'(s);
          finished = 1'b1;
        end
      end
      // A lookup gives up at the first bucket that still has room and no match.
      if (!finished && op != KIND_INSERT && has_empty) finished = 1'b1;
      step++;
    end
    return r;
  endfunction

  // Keys are either fully random or members of a few same-home families.
  function automatic logic [KEY_W-1:0] fresh_key();
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom);
    return (KEY_W'($urandom_range(0, 127)) << FRAC_W) |
           KEY_W'(cluster_base[$urandom_range(0, 5)]);
  endfunction

  function automatic void add_case(input logic cfg_en, input logic [CFG_INDEX_W-1:0] cfg_idx,
                                   input logic [LIMIT_W-1:0] cfg_val,
                                   input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
                                   input logic [OFFSET_W-1:0] ofs, input logic typed,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [OFFSET_W-1:0] fo, input int unsigned b,
                                   input int unsigned s, input int unsigned c);
    probe_case_t row;
    row.cfg_en = cfg_en;
    row.cfg_idx = cfg_idx;
    row.cfg_val = cfg_val;
    row.op = op;
    row.key = k;
    row.ofs = ofs;
    row.typed = typed;
    row.res.status = st;
    row.res.found_offset = fo;
    row.res.bucket = BUCKET_W'(b);
    row.res.slot = SLOT_W'(s);
    row.res.count = COUNT_W'(c);
    directed_cases = {directed_cases, row};
  endfunction

  // Presents one request, waits for it to be taken, and records its expected result.
  task automatic issue(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
                       input logic [OFFSET_W-1:0] ofs, input logic typed,
                       input result_t typed_res, input int unsigned gap);
    result_t predicted;
    @(negedge clk);
    start = 1'b1;
    kind = op;
    key = k;
    record_offset = ofs;
    do @(posedge clk); while (busy);
    predicted = walk_table(op, k, ofs);
    pending_replies = {pending_replies, (typed ? typed_res : predicted)};
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every outstanding request has been answered.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PROBE_MODE) cfg_quadratic = val[0];
    else cfg_limit = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin : check_replies
    result_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d offset %h bucket %0d slot %0d probes %0d",
                   status, found_offset, bucket_index, slot_index, probe_count);
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status || found_offset !== want.found_offset ||
            bucket_index !== want.bucket || slot_index !== want.slot ||
            probe_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected status %0d offset %h bucket %0d slot %0d ",
                      "probes %0d, got status %0d offset %h bucket %0d slot %0d probes %0d"},
                     want.status, want.found_offset, want.bucket, want.slot, want.count,
                     status, found_offset, bucket_index, slot_index, probe_count);
        end
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]   key_pool [$];
    logic [KEY_W-1:0]   k;
    logic [KIND_W-1:0]  op;
    logic [LIMIT_W-1:0] lim_val;
    logic [LIMIT_W-1:0] mode_val;
    int unsigned        pick, gap, burst;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_INSERT;
    key = '0;
    record_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROBE_MODE;
    cfg_data = '0;
    cfg_quadratic = 1'b0;
    cfg_limit = LIMIT_MAX;
    burst = 0;
    for (int i = 0; i < BUCKETS * SLOTS; i++) begin
      tag_store[i] = TAG_EMPTY;
      key_store[i] = '0;
      offset_store[i] = '0;
    end
    for (int i = 0; i < 6; i++) cluster_base[i] = FRAC_W'($urandom);

    // Directed rows. Keys 0, F, 2F, ... all share home bucket 0.
    add_case(0, CFG_PROBE_MODE, 0, KIND_SEARCH, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 1);
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, 0, 32'hFFFF_FFFF, 1, ST_DONE, 0, 0, 0, 1);
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, FAMILY_STEP, 32'h1, 1, ST_DONE, 0, 0, 1, 1);
    // A duplicate key is stored again further along the path.
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, 0, 32'h22, 1, ST_DONE, 0, 1, 0, 2);
    add_case(0, CFG_PROBE_MODE, 0, KIND_SEARCH, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0, 0, 1);
    add_case(0, CFG_PROBE_MODE, 0, KIND_DELETE, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0, 0, 1);
    // The tombstone is skipped and the second copy is found.
    add_case(0, CFG_PROBE_MODE, 0, KIND_SEARCH, 0, 0, 1, ST_DONE, 32'h22, 1, 0, 2);
    add_case(0, CFG_PROBE_MODE, 0, KIND_SPARE, FAMILY_STEP, 0, 1, ST_DONE, 32'h1, 0, 1, 1);
    add_case(0, CFG_PROBE_MODE, 0, KIND_SEARCH, FAMILY_2, 0, 1, ST_NOT_FOUND,
             0, 0, 0, 2);
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, 31'h7FFF_FFFF, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_case(0, CFG_PROBE_MODE, 0, KIND_SEARCH, 31'h7FFF_FFFF, 0, 0, ST_DONE, 0, 0, 0, 0);
    // A zero limit behaves as one.
    add_case(1, CFG_PROBE_LIMIT, 0, KIND_INSERT, FAMILY_2, 32'h0F0F_0F0F, 1,
             ST_DONE, 0, 1, 1, 2);
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, FAMILY_3, 32'h3, 1, ST_FULL,
             0, 0, 0, 2);
    add_case(0, CFG_PROBE_MODE, 0, KIND_SEARCH, FAMILY_4, 0, 1, ST_NOT_FOUND,
             0, 0, 0, 2);
    // Quadratic probing with stored entries: the path now jumps to bucket 4.
    add_case(1, CFG_PROBE_MODE, 11'h001, KIND_SEARCH, FAMILY_3, 0, 1, ST_NOT_FOUND,
             0, 0, 0, 2);
    add_case(1, CFG_PROBE_LIMIT, 2, KIND_INSERT, FAMILY_3, 32'hA5A5_A5A5, 1,
             ST_DONE, 0, 4, 0, 3);
    // A limit above the maximum is clamped.
    add_case(1, CFG_PROBE_LIMIT, 11'h7FF, KIND_SEARCH, FAMILY_3, 0, 1, ST_DONE,
             32'hA5A5_A5A5, 4, 0, 3);
    // Only the low bit of the mode data counts.
    add_case(1, CFG_PROBE_MODE, 11'h7FE, KIND_SEARCH, FAMILY_3, 0, 1, ST_NOT_FOUND,
             0, 0, 0, 3);
    add_case(1, CFG_PROBE_LIMIT, LIMIT_MAX, KIND_DELETE, FAMILY_3, 0, 1,
             ST_NOT_FOUND, 0, 0, 0, 3);
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, 1, 32'h5A5A_5A5A, 0, ST_DONE, 0, 0, 0, 0);
    add_case(0, CFG_PROBE_MODE, 0, KIND_DELETE, 31'h7FFF_FFFF, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_case(0, CFG_PROBE_MODE, 0, KIND_SPARE, 31'h7FFF_FFFF, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_case(0, CFG_PROBE_MODE, 0, KIND_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0,
             ST_DONE, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part; register writes wait for the block to drain.
    foreach (directed_cases[i]) begin
      if (directed_cases[i].cfg_en) begin
        settle();
        set_reg(directed_cases[i].cfg_idx, directed_cases[i].cfg_val);
      end
      issue(directed_cases[i].op, directed_cases[i].key, directed_cases[i].ofs,
            directed_cases[i].typed, directed_cases[i].res, $urandom_range(0, 18));
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      unique case (ph)
        0, 1: lim_val = LIMIT_MAX;
        2: lim_val = 3;
        3: lim_val = 0;
        4: lim_val = 16;
        5: lim_val = 200;
        6: lim_val = 11'h7FF;
        default: lim_val = LIMIT_W'($urandom_range(1, 2047));
      endcase
      mode_val = LIMIT_W'($urandom);
      mode_val[0] = ph[0];
      set_reg(CFG_PROBE_MODE, mode_val);
      set_reg(CFG_PROBE_LIMIT, lim_val);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // Mostly random gaps, with occasional back-to-back bursts.
        if (burst > 0) begin
          gap = 0;
          burst--;
        end else if ($urandom_range(0, 19) == 0) begin
          gap = 0;
          burst = $urandom_range(10, 40);
        end else begin
          gap = $urandom_range(0, 18);
        end
        // Inserts, plus searches, deletes and the spare code on stored keys; the rest are misses.
        pick = $urandom_range(0, 99);
        if (pick < 35 || key_pool.size() == 0) begin
          op = KIND_INSERT;
          if (key_pool.size() != 0 && $urandom_range(0, 6) == 0)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else
            k = fresh_key();
          key_pool = {key_pool, k};
          if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
        end else begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          if (pick < 65) op = KIND_SEARCH;
          else if (pick < 80) op = KIND_DELETE;
          else if (pick < 94) op = KIND_SPARE;
          else begin
            op = (pick < 97) ? KIND_SEARCH : KIND_DELETE;
            k = fresh_key();
          end
        end
        issue(op, k, $urandom, 1'b0, '0, gap);
        // Now and then the sender holds off until the block is empty.
        if ($urandom_range(0, 59) == 0) settle();
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
